// ----- hdl/fmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types and constants for the single-precision remainder block.
// ----------------------------------------------------------------------------
package fmr_pkg;

    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] EXP_MASK   = 32'h7F80_0000;
    localparam logic [31:0] MAN_MASK   = 32'h007F_FFFF;
    localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
    localparam logic [31:0] QNAN_CANON = 32'h7FC0_0000;
    localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
    localparam logic [7:0]  EXP_ALL    = 8'hFF;

    localparam int DEFAULT_QUEUE_DEPTH = 2;

    // One item handed from the front to the back.
    typedef struct packed {
        logic               special;
        logic [31:0]        result;
        logic               sign;
        logic [23:0]        mx;
        logic [23:0]        my;
        logic signed [9:0]  ex;
        logic signed [9:0]  ey;
    } fmr_item_t;

    typedef enum logic [0:0] {
        F_IDLE,
        F_NORM
    } fmr_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_NORM,
        B_DONE
    } fmr_back_state_t;

endpackage

// ----- hdl/fmr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_front
// Accepts operands, resolves special cases and normalizes subnormal inputs.
// ----------------------------------------------------------------------------
module fmr_front
    import fmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend_bits,
    input  logic [31:0] divisor_bits,
    output logic        busy,
    input  logic        q_full,
    output logic        push,
    output fmr_item_t   push_item
);

    fmr_front_state_t state_reg, state_next;
    fmr_item_t        item_reg, item_next;

    logic        accept;
    logic [31:0] ax, ay;
    logic        nan_x, nan_y;
    logic        norm_done;
    fmr_item_t   cls;

    assign accept = start && !busy;
    assign ax     = dividend_bits << 1;
    assign ay     = divisor_bits << 1;
    assign nan_x  = (dividend_bits & ~SIGN_MASK) > EXP_MASK;
    assign nan_y  = (divisor_bits & ~SIGN_MASK) > EXP_MASK;

    // Classification of the incoming pair.
    always_comb
    begin
        cls         = '0;
        cls.sign    = dividend_bits[31];
        cls.special = 1'b1;
        cls.mx      = {(dividend_bits[30:23] != 8'd0), dividend_bits[22:0]};
        cls.my      = {(divisor_bits[30:23] != 8'd0), divisor_bits[22:0]};
        cls.ex      = (dividend_bits[30:23] == 8'd0) ? 10'sd1
                                                      : $signed({2'b00, dividend_bits[30:23]});
        cls.ey      = (divisor_bits[30:23] == 8'd0) ? 10'sd1
                                                     : $signed({2'b00, divisor_bits[30:23]});
        if (nan_x)
            cls.result = dividend_bits | QUIET_BIT;
        else if (nan_y)
            cls.result = divisor_bits | QUIET_BIT;
        else if (ay == 32'd0 || dividend_bits[30:23] == EXP_ALL)
            cls.result = QNAN_CANON;
        else if (ax == ay)
            cls.result = dividend_bits & SIGN_MASK;
        else if (ax < ay)
            cls.result = dividend_bits;
        else
        begin
            cls.result  = '0;
            cls.special = 1'b0;
        end
    end

    assign norm_done = item_reg.mx[23] && item_reg.my[23];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
                if (accept && !cls.special)
                    state_next = F_NORM;
            F_NORM:
                if (norm_done && !q_full)
                    state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        item_next = item_reg;
        case (state_reg)
            F_IDLE:
                if (accept)
                    item_next = cls;
            F_NORM:
            begin
                if (!item_reg.mx[23])
                begin
                    item_next.mx = item_reg.mx << 1;
                    item_next.ex = item_reg.ex - 10'sd1;
                end
                if (!item_reg.my[23])
                begin
                    item_next.my = item_reg.my << 1;
                    item_next.ey = item_reg.ey - 10'sd1;
                end
            end
            default:
                item_next = item_reg;
        endcase
    end

    // Outputs: specials go straight into the queue at acceptance.
    always_comb
    begin
        busy      = 1'b0;
        push      = 1'b0;
        push_item = cls;
        case (state_reg)
            F_IDLE:
            begin
                busy = q_full;
                push = accept && cls.special;
            end
            F_NORM:
            begin
                busy      = 1'b1;
                push      = norm_done && !q_full;
                push_item = item_reg;
            end
            default:
                busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ----- hdl/fmr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module fmr_queue
    import fmr_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  fmr_item_t push_item,
    input  logic      pop,
    output fmr_item_t pop_item,
    output logic      full,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fmr_item_t         mem_reg [DEPTH];
    logic [PW-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

// ----- hdl/fmr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_back
// Shift-and-subtract long division and result packing.
// ----------------------------------------------------------------------------
module fmr_back
    import fmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  fmr_item_t   q_item,
    output logic        pop,
    output logic        done,
    output logic [31:0] remainder_bits
);

    fmr_back_state_t   state_reg, state_next;
    logic [24:0]       mx_reg, mx_next;
    logic [23:0]       my_reg, my_next;
    logic signed [9:0] ex_reg, ex_next, ey_reg, ey_next;
    logic              sign_reg, sign_next;
    logic [31:0]       res_reg, res_next;

    logic              ge, exact;
    logic [24:0]       diff, kept;
    logic signed [9:0] sh;

    assign ge    = mx_reg >= {1'b0, my_reg};
    assign diff  = mx_reg - {1'b0, my_reg};
    assign exact = ge && (diff == 25'd0);
    assign kept  = ge ? diff : mx_reg;
    assign sh    = 10'sd1 - ex_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                    state_next = q_item.special ? B_DONE : B_DIV;
            B_DIV:
                if (exact)
                    state_next = B_DONE;
                else if (ex_reg <= ey_reg)
                    state_next = B_NORM;
            B_NORM:
                if (mx_reg[23])
                    state_next = B_DONE;
            B_DONE:
                state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        mx_next   = mx_reg;
        my_next   = my_reg;
        ex_next   = ex_reg;
        ey_next   = ey_reg;
        sign_next = sign_reg;
        res_next  = res_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                begin
                    mx_next   = {1'b0, q_item.mx};
                    my_next   = q_item.my;
                    ex_next   = q_item.ex;
                    ey_next   = q_item.ey;
                    sign_next = q_item.sign;
                    res_next  = q_item.result;
                end
            B_DIV:
                if (exact)
                    res_next = {sign_reg, 31'd0};
                else if (ex_reg > ey_reg)
                begin
                    mx_next = kept << 1;
                    ex_next = ex_reg - 10'sd1;
                end
                else
                    mx_next = kept;
            B_NORM:
                if (!mx_reg[23])
                begin
                    mx_next = mx_reg << 1;
                    ex_next = ex_reg - 10'sd1;
                end
                else if (ex_reg > 10'sd0)
                    res_next = {sign_reg, ex_reg[7:0], mx_reg[22:0]};
                else if (sh >= 10'sd32)
                    res_next = {sign_reg, 31'd0};
                else
                    res_next = {sign_reg, 31'(mx_reg[23:0] >> sh[4:0])};
            default:
                res_next = res_reg;
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        done = 1'b0;
        case (state_reg)
            B_IDLE:
                pop = !q_empty;
            B_DONE:
                done = 1'b1;
            default:
                pop = 1'b0;
        endcase
    end

    assign remainder_bits = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        sign_reg <= sign_next;
        res_reg  <= res_next;
    end

endmodule

// ----- hdl/float32_remainder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_remainder
// Exact IEEE-754 single-precision truncated remainder, fmod(x, y).
// ----------------------------------------------------------------------------
// Usage: drive dividend_bits and divisor_bits and raise start. The operand
// transfer takes place at the rising edge where start is high and busy is low.
// Each transfer yields exactly one result: remainder_bits is valid for the
// single cycle in which done is high, and it must be taken then, since the
// receiver cannot stall the block.
// The front classifies the operands: NaNs, a zero divisor, an infinite
// dividend, equal magnitudes and a smaller dividend resolve at once. Other
// pairs have subnormal significands normalized, one bit per cycle, before
// they enter a short queue. The back runs one compare, subtract and shift
// per unit of exponent difference, then renormalizes the remainder one bit
// per cycle and packs it. The division loop in the back sets the throughput.
// The queue lets the front take the next item while the back is working.
// Reset clears the control state of both parts and empties the queue; no
// result is produced until a new transfer.
// ----------------------------------------------------------------------------
module float32_remainder
    import fmr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] dividend_bits,
    input  logic [31:0] divisor_bits,
    output logic        done,
    output logic [31:0] remainder_bits
);

    // Front-to-queue and queue-to-back links.
    logic      push, pop, q_full, q_empty;
    fmr_item_t push_item, pop_item;

    fmr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .dividend_bits (dividend_bits),
        .divisor_bits  (divisor_bits),
        .busy          (busy),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    fmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    fmr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (pop_item),
        .pop            (pop),
        .done           (done),
        .remainder_bits (remainder_bits)
    );

endmodule

// ----- tb/fmod_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmod_checker
// Watches the operand and result transfers of the remainder block, predicts
// each result from the operands and compares it with what the block returns.
// ----------------------------------------------------------------------------
module fmod_checker
    import fmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] dividend_bits,
    input  logic [31:0] divisor_bits,
    input  logic        done,
    input  logic [31:0] remainder_bits,
    output int          error_count,
    output int          pending_count
);

    logic [31:0] remainder_queue[$];

    function automatic logic is_nan(input logic [31:0] u);
        return u[30:0] > EXP_MASK[30:0];
    endfunction

    // Turns a finite nonzero operand into a significand with bit 23 set.
    function automatic logic [31:0] normalize_sig(input logic [31:0] u,
                                                  output int e);
        logic [31:0] m;
        m = u & MAN_MASK;
        e = int'(u[30:23]);
        if (e != 0)
            return m | HIDDEN_BIT;
        e = 1;
        for (int i = 0; i < 24 && (m & HIDDEN_BIT) == 0; i++)
        begin
            m = m << 1;
            e--;
        end
        return m;
    endfunction

    function automatic logic [31:0] fmod_value(input logic [31:0] x,
                                               input logic [31:0] y);
        logic [31:0] sx, ax, ay, mx, my;
        int ex, ey, sh;
        sx = x & SIGN_MASK;
        ax = x << 1;
        ay = y << 1;
        if (is_nan(x))
            return x | QUIET_BIT;
        if (is_nan(y))
            return y | QUIET_BIT;
        if (ay == 0 || x[30:23] == EXP_ALL)
            return QNAN_CANON;
        if (ax == ay)
            return sx;
        if (ax < ay)
            return x;
        mx = normalize_sig(x, ex);
        my = normalize_sig(y, ey);
        for (; ex > ey; ex--)
        begin
            if (mx >= my)
            begin
                mx = mx - my;
                if (mx == 0)
                    return sx;
            end
            mx = mx << 1;
        end
        if (mx >= my)
        begin
            mx = mx - my;
            if (mx == 0)
                return sx;
        end
        for (int i = 0; i < 24 && (mx & HIDDEN_BIT) == 0; i++)
        begin
            mx = mx << 1;
            ex--;
        end
        if (ex > 0)
            return sx | (mx - HIDDEN_BIT) | (32'(ex) << 23);
        sh = 1 - ex;
        if (sh >= 32)
            return sx;
        return sx | (mx >> sh);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    initial
    begin
        error_count   = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (remainder_queue.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", remainder_bits));
                else if (remainder_queue[0] !== remainder_bits)
                    report_mismatch($sformatf("remainder_bits %h, expected %h",
                                              remainder_bits, remainder_queue[0]));
                if (remainder_queue.size() != 0)
                    void'(remainder_queue.pop_front());
            end
            if (start && !busy)
                remainder_queue.push_back(fmod_value(dividend_bits, divisor_bits));
            pending_count = remainder_queue.size();
        end
    end

endmodule

// ----- tb/tb_float32_remainder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float32_remainder
// Drives operand pairs into the remainder block and gives the verdict.
// ----------------------------------------------------------------------------
// A directed set covers NaNs, infinities, zeros, subnormals, equal magnitudes
// and exact division; random pairs follow, mostly with nearby exponents so
// the division loop stays short, a few across the whole exponent range.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_float32_remainder;

    import fmr_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] dividend_bits;
    logic [31:0] divisor_bits;
    logic        done;
    logic [31:0] remainder_bits;
    int          error_count;
    int          pending_count;
    int          cycle_count;
    logic        calm_stretch;

    float32_remainder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .dividend_bits  (dividend_bits),
        .divisor_bits   (divisor_bits),
        .done           (done),
        .remainder_bits (remainder_bits)
    );

    fmod_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .dividend_bits  (dividend_bits),
        .divisor_bits   (divisor_bits),
        .done           (done),
        .remainder_bits (remainder_bits),
        .error_count    (error_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The run ends on its own if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[float32_remainder] ERROR");
            $finish;
        end
    end

    // One operand transfer. Values change at the falling edge; start stays
    // high from one transfer into the next unless an idle gap is chosen.
    // Busy only moves at a rising edge, so its value at a falling edge is
    // the one the next rising edge sees.
    task automatic send_pair(input logic [31:0] x, input logic [31:0] y);
        while (!calm_stretch && $urandom_range(99) < 18)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start         <= 1'b1;
        dividend_bits <= x;
        divisor_bits  <= y;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    // A random single with a biased exponent near the given center.
    function automatic logic [31:0] pick_float(input int center, input int spread);
        int e;
        e = center + $urandom_range(2 * spread) - spread;
        if (e < 0)
            e = 0;
        if (e > 255)
            e = 255;
        return {1'($urandom), 8'(e), 23'($urandom)};
    endfunction

    logic [31:0] directed_x[$];
    logic [31:0] directed_y[$];

    task automatic add_pair(input logic [31:0] x, input logic [31:0] y);
        directed_x.push_back(x);
        directed_y.push_back(y);
    endtask

    initial
    begin
        int center;
        logic [31:0] x, y;
        rst_n         = 1'b0;
        start         = 1'b0;
        dividend_bits = '0;
        divisor_bits  = '0;
        cycle_count   = 0;
        calm_stretch  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed cases: NaN dividend (signaling and quiet), NaN divisor,
        // zero divisor, infinite dividend, equal magnitudes, smaller dividend,
        // zero dividend, infinite divisor, exact division, subnormals, and the
        // widest exponent gap.
        add_pair(32'hFF80_0001, 32'h3F80_0000);
        add_pair(32'h7FC1_2345, 32'h7F80_0001);
        add_pair(32'h3F80_0000, 32'hFFA0_0000);
        add_pair(32'h4040_0000, 32'h8000_0000);
        add_pair(32'hFF80_0000, 32'h3F80_0000);
        add_pair(32'hC0A0_0000, 32'h40A0_0000);
        add_pair(32'h3F00_0000, 32'h4000_0000);
        add_pair(32'h8000_0000, 32'h3F80_0000);
        add_pair(32'h4B00_0001, 32'h7F80_0000);
        add_pair(32'h40C0_0000, 32'h4040_0000);
        add_pair(32'h0000_0001, 32'h0000_0001);
        add_pair(32'h007F_FFFF, 32'h0000_0003);
        add_pair(32'h3F80_0000, 32'h0000_0001);
        add_pair(32'h7F7F_FFFF, 32'h0000_0001);
        add_pair(32'hFF7F_FFFF, 32'h8000_0003);
        add_pair(32'h7F7F_FFFF, 32'h3F80_0001);
        add_pair(32'h0080_0001, 32'h0080_0000);
        add_pair(32'h4049_0FDB, 32'h3FC9_0FDB);
        add_pair(32'hFFFF_FFFF, 32'h0000_0000);
        add_pair(32'h0000_0000, 32'h0000_0000);
        add_pair(32'h0100_0001, 32'h0080_0001);
        for (int i = 0; i < directed_x.size(); i++)
            send_pair(directed_x[i], directed_y[i]);

        // Random pairs. Around the middle a stretch without idling runs,
        // and once the sender waits until every result is back.
        for (int i = 0; i < 1300; i++)
        begin
            calm_stretch = (i >= 500 && i < 650);
            if (i == 700)
            begin
                start <= 1'b0;
                @(negedge clk);
                while (pending_count != 0)
                    @(negedge clk);
            end
            case ($urandom_range(9))
                0:
                begin
                    x = $urandom;
                    y = $urandom;
                end
                1:
                begin
                    x = pick_float(0, 2);
                    y = pick_float(0, 2);
                end
                2:
                begin
                    x = pick_float(255, 3);
                    y = pick_float($urandom_range(255), 3);
                    if ($urandom_range(1))
                    begin
                        x = y;
                        y = pick_float($urandom_range(255), 3);
                    end
                end
                3:
                begin
                    y = pick_float($urandom_range(250), 3);
                    x = {$urandom_range(1) ? 1'b1 : 1'b0, y[30:0]};
                    if ($urandom_range(1))
                        x[30:23] = y[30:23] + 8'($urandom_range(2));
                end
                4:
                begin
                    // Small integers give exact division often.
                    x = {$urandom_range(1) ? 1'b1 : 1'b0, 8'(127 + $urandom_range(10)),
                         8'($urandom), 15'h0};
                    y = {$urandom_range(1) ? 1'b1 : 1'b0, 8'(127 + $urandom_range(3)),
                         2'($urandom), 21'h0};
                end
                default:
                begin
                    center = $urandom_range(20, 235);
                    x = pick_float(center, 12);
                    y = pick_float(center - 6, 12);
                end
            endcase
            send_pair(x, y);
        end

        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (error_count == 0)
            $display("[float32_remainder] OK");
        else
            $display("[float32_remainder] ERROR");
        $finish;
    end

endmodule
